>>> src/rvdec_pkg.sv
// Shared codes for the RV32I instruction decoder: major opcodes, instruction
// codes, immediate formats, memory access kinds and operand patterns.
// No dependencies.
package rvdec_pkg;

  // Major opcodes, instruction bits 6:2.
  localparam logic [4:0] OPC_LOAD     = 5'h00;
  localparam logic [4:0] OPC_MISC_MEM = 5'h03;
  localparam logic [4:0] OPC_OP_IMM   = 5'h04;
  localparam logic [4:0] OPC_AUIPC    = 5'h05;
  localparam logic [4:0] OPC_STORE    = 5'h08;
  localparam logic [4:0] OPC_OP       = 5'h0c;
  localparam logic [4:0] OPC_LUI      = 5'h0d;
  localparam logic [4:0] OPC_BRANCH   = 5'h18;
  localparam logic [4:0] OPC_JALR     = 5'h19;
  localparam logic [4:0] OPC_JAL      = 5'h1b;
  localparam logic [4:0] OPC_SYSTEM   = 5'h1c;

  // Function fields of SYSTEM with funct3 zero.
  localparam logic [11:0] F12_ECALL  = 12'h000;
  localparam logic [11:0] F12_EBREAK = 12'h001;
  localparam logic [11:0] F12_MRET   = 12'h302;
  localparam logic [11:0] F12_WFI    = 12'h105;

  // Instruction codes.
  localparam logic [5:0] IC_UNKNOWN = 6'd0;
  localparam logic [5:0] IC_LUI     = 6'd1;
  localparam logic [5:0] IC_AUIPC   = 6'd2;
  localparam logic [5:0] IC_JAL     = 6'd3;
  localparam logic [5:0] IC_JALR    = 6'd4;
  localparam logic [5:0] IC_BEQ     = 6'd5;
  localparam logic [5:0] IC_BNE     = 6'd6;
  localparam logic [5:0] IC_BLT     = 6'd7;
  localparam logic [5:0] IC_BGE     = 6'd8;
  localparam logic [5:0] IC_BLTU    = 6'd9;
  localparam logic [5:0] IC_BGEU    = 6'd10;
  localparam logic [5:0] IC_LB      = 6'd11;
  localparam logic [5:0] IC_LH      = 6'd12;
  localparam logic [5:0] IC_LW      = 6'd13;
  localparam logic [5:0] IC_LBU     = 6'd14;
  localparam logic [5:0] IC_LHU     = 6'd15;
  localparam logic [5:0] IC_SB      = 6'd16;
  localparam logic [5:0] IC_SH      = 6'd17;
  localparam logic [5:0] IC_SW      = 6'd18;
  localparam logic [5:0] IC_ADDI    = 6'd19;
  localparam logic [5:0] IC_SLLI    = 6'd20;
  localparam logic [5:0] IC_SLTI    = 6'd21;
  localparam logic [5:0] IC_SLTIU   = 6'd22;
  localparam logic [5:0] IC_XORI    = 6'd23;
  localparam logic [5:0] IC_SRLI    = 6'd24;
  localparam logic [5:0] IC_SRAI    = 6'd25;
  localparam logic [5:0] IC_ORI     = 6'd26;
  localparam logic [5:0] IC_ANDI    = 6'd27;
  localparam logic [5:0] IC_ADD     = 6'd28;
  localparam logic [5:0] IC_SUB     = 6'd29;
  localparam logic [5:0] IC_SLL     = 6'd30;
  localparam logic [5:0] IC_SLT     = 6'd31;
  localparam logic [5:0] IC_SLTU    = 6'd32;
  localparam logic [5:0] IC_XOR     = 6'd33;
  localparam logic [5:0] IC_SRL     = 6'd34;
  localparam logic [5:0] IC_SRA     = 6'd35;
  localparam logic [5:0] IC_OR      = 6'd36;
  localparam logic [5:0] IC_AND     = 6'd37;
  localparam logic [5:0] IC_FENCE   = 6'd38;
  localparam logic [5:0] IC_FENCE_I = 6'd39;
  localparam logic [5:0] IC_ECALL   = 6'd40;
  localparam logic [5:0] IC_EBREAK  = 6'd41;
  localparam logic [5:0] IC_MRET    = 6'd42;
  localparam logic [5:0] IC_WFI     = 6'd43;
  localparam logic [5:0] IC_CSRRW   = 6'd44;
  localparam logic [5:0] IC_CSRRS   = 6'd45;
  localparam logic [5:0] IC_CSRRC   = 6'd46;
  localparam logic [5:0] IC_CSRRWI  = 6'd47;
  localparam logic [5:0] IC_CSRRSI  = 6'd48;
  localparam logic [5:0] IC_CSRRCI  = 6'd49;

  // Immediate formats.
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_I    = 3'd1;
  localparam logic [2:0] FMT_S    = 3'd2;
  localparam logic [2:0] FMT_B    = 3'd3;
  localparam logic [2:0] FMT_U    = 3'd4;
  localparam logic [2:0] FMT_J    = 3'd5;

  // Memory access kinds.
  localparam logic [3:0] MEM_NONE = 4'd0;
  localparam logic [3:0] MEM_LB   = 4'd1;
  localparam logic [3:0] MEM_LH   = 4'd2;
  localparam logic [3:0] MEM_LW   = 4'd3;
  localparam logic [3:0] MEM_LBU  = 4'd4;
  localparam logic [3:0] MEM_LHU  = 4'd5;
  localparam logic [3:0] MEM_SB   = 4'd6;
  localparam logic [3:0] MEM_SH   = 4'd7;
  localparam logic [3:0] MEM_SW   = 4'd8;

  // Operand patterns.
  localparam logic [3:0] PAT_NONE        = 4'd0;
  localparam logic [3:0] PAT_RD_RS1_RS2  = 4'd1;
  localparam logic [3:0] PAT_RD_RS1_IMM  = 4'd2;
  localparam logic [3:0] PAT_RD_RS1_SHAMT = 4'd3;
  localparam logic [3:0] PAT_RD_IMM      = 4'd4;
  localparam logic [3:0] PAT_RD_OFF_RS1  = 4'd5;
  localparam logic [3:0] PAT_RS2_OFF_RS1 = 4'd6;
  localparam logic [3:0] PAT_RS1_RS2_TGT = 4'd7;
  localparam logic [3:0] PAT_RD_TGT      = 4'd8;
  localparam logic [3:0] PAT_PRED_SUCC   = 4'd9;
  localparam logic [3:0] PAT_RD_CSR_RS1  = 4'd10;
  localparam logic [3:0] PAT_RD_CSR_ZIMM = 4'd11;

endpackage

>>> src/rv32i_instruction_decoder.sv
// RV32I instruction decoder: one input register, a decode stage and a
// result register. Depends on rvdec_pkg for all codes.
//
// Usage:
//   An item (pc, instr_word) is taken at a rising edge where start is high
//   and busy is low. busy is always low, so an item may be offered in every
//   clock cycle.
//   The item is captured in the input register at the accepting edge, decoded
//   combinationally from there, and its result is then held in the result
//   register and shown on the result ports, marked by done.
//   Throughput is one item per cycle; the decode logic and the pc plus
//   immediate adder between the two register stages set the cycle time.
//   Each result is shown for exactly one cycle and the receiver cannot
//   stall the block, so nothing is ever held back.
//   Reset (rst, synchronous, active high) clears the valid flags of both
//   stages; the data registers of both stages are not reset.
//   A word whose two low bits are not both set yields a result of all zeros.
module rv32i_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        pc,
  input  logic [31:0]        instr_word,
  output logic               done,
  output logic [5:0]         instr_code,
  output logic [2:0]         imm_format,
  output logic signed [31:0] immediate,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic [4:0]         dest_reg,
  output logic [11:0]        csr_index,
  output logic [7:0]         fence_order,
  output logic [31:0]        target,
  output logic               writes_dest,
  output logic [3:0]         mem_op,
  output logic [3:0]         operand_pattern
);
  import rvdec_pkg::*;

  // Input register stage.
  logic        in_valid;
  logic [31:0] in_pc;
  logic [31:0] in_word;

  // Decoded values of the item in the input register.
  logic        full_size;
  logic [4:0]  op;
  logic [2:0]  f3;
  logic        alt;
  logic [11:0] f12;
  logic        sign;
  logic [5:0]  code_next;
  logic [2:0]  fmt_next;
  logic        wr_next;
  logic [3:0]  mem_next;
  logic [3:0]  pat_next;
  logic [31:0] imm_next;
  logic [31:0] target_next;

  // The block never refuses an item.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_pc   <= pc;
      in_word <= instr_word;
    end
  end

  // Field extraction.
  assign full_size = (in_word[1:0] == 2'b11);
  assign op        = in_word[6:2];
  assign f3        = in_word[14:12];
  assign alt       = in_word[30];
  assign f12       = in_word[31:20];
  assign sign      = in_word[31];

  // Class, code and attributes from opcode, funct3, bit 30 and bits 31:20.
  always_comb begin
    code_next = IC_UNKNOWN;
    fmt_next  = FMT_NONE;
    wr_next   = 1'b0;
    mem_next  = MEM_NONE;
    pat_next  = PAT_NONE;
    unique case (op)
      OPC_LUI: begin
        code_next = IC_LUI;
        fmt_next  = FMT_U;
        wr_next   = 1'b1;
        pat_next  = PAT_RD_IMM;
      end
      OPC_AUIPC: begin
        code_next = IC_AUIPC;
        fmt_next  = FMT_U;
        wr_next   = 1'b1;
        pat_next  = PAT_RD_IMM;
      end
      OPC_JAL: begin
        code_next = IC_JAL;
        fmt_next  = FMT_J;
        wr_next   = 1'b1;
        pat_next  = PAT_RD_TGT;
      end
      OPC_JALR: begin
        code_next = IC_JALR;
        fmt_next  = FMT_I;
        wr_next   = 1'b1;
        pat_next  = PAT_RD_OFF_RS1;
      end
      OPC_BRANCH: begin
        fmt_next = FMT_B;
        pat_next = PAT_RS1_RS2_TGT;
        unique case (f3)
          3'd0:    code_next = IC_BEQ;
          3'd1:    code_next = IC_BNE;
          3'd4:    code_next = IC_BLT;
          3'd5:    code_next = IC_BGE;
          3'd6:    code_next = IC_BLTU;
          3'd7:    code_next = IC_BGEU;
          default: code_next = IC_UNKNOWN;
        endcase
      end
      OPC_LOAD: begin
        fmt_next = FMT_I;
        wr_next  = 1'b1;
        pat_next = PAT_RD_OFF_RS1;
        unique case (f3)
          3'd0: begin
            code_next = IC_LB;
            mem_next  = MEM_LB;
          end
          3'd1: begin
            code_next = IC_LH;
            mem_next  = MEM_LH;
          end
          3'd2: begin
            code_next = IC_LW;
            mem_next  = MEM_LW;
          end
          3'd4: begin
            code_next = IC_LBU;
            mem_next  = MEM_LBU;
          end
          3'd5: begin
            code_next = IC_LHU;
            mem_next  = MEM_LHU;
          end
          default: begin
            code_next = IC_UNKNOWN;
            mem_next  = MEM_NONE;
          end
        endcase
      end
      OPC_STORE: begin
        fmt_next = FMT_S;
        pat_next = PAT_RS2_OFF_RS1;
        unique case (f3)
          3'd0: begin
            code_next = IC_SB;
            mem_next  = MEM_SB;
          end
          3'd1: begin
            code_next = IC_SH;
            mem_next  = MEM_SH;
          end
          3'd2: begin
            code_next = IC_SW;
            mem_next  = MEM_SW;
          end
          default: begin
            code_next = IC_UNKNOWN;
            mem_next  = MEM_NONE;
          end
        endcase
      end
      OPC_OP_IMM: begin
        fmt_next = FMT_I;
        wr_next  = 1'b1;
        pat_next = ((f3 == 3'd1) || (f3 == 3'd5)) ? PAT_RD_RS1_SHAMT : PAT_RD_RS1_IMM;
        unique case (f3)
          3'd0:    code_next = IC_ADDI;
          3'd1:    code_next = IC_SLLI;
          3'd2:    code_next = IC_SLTI;
          3'd3:    code_next = IC_SLTIU;
          3'd4:    code_next = IC_XORI;
          3'd5:    code_next = alt ? IC_SRAI : IC_SRLI;
          3'd6:    code_next = IC_ORI;
          default: code_next = IC_ANDI;
        endcase
      end
      OPC_OP: begin
        wr_next  = 1'b1;
        pat_next = PAT_RD_RS1_RS2;
        unique case (f3)
          3'd0:    code_next = alt ? IC_SUB : IC_ADD;
          3'd1:    code_next = IC_SLL;
          3'd2:    code_next = IC_SLT;
          3'd3:    code_next = IC_SLTU;
          3'd4:    code_next = IC_XOR;
          3'd5:    code_next = alt ? IC_SRA : IC_SRL;
          3'd6:    code_next = IC_OR;
          default: code_next = IC_AND;
        endcase
      end
      OPC_MISC_MEM: begin
        if (f3 == 3'd0) begin
          code_next = IC_FENCE;
          fmt_next  = FMT_I;
          pat_next  = PAT_PRED_SUCC;
        end else if (f3 == 3'd1) begin
          code_next = IC_FENCE_I;
          fmt_next  = FMT_I;
        end
      end
      OPC_SYSTEM: begin
        unique case (f3) inside
          3'd0: begin
            // Privileged and environment calls are told apart by bits 31:20.
            fmt_next = FMT_I;
            unique case (f12)
              F12_ECALL:  code_next = IC_ECALL;
              F12_EBREAK: code_next = IC_EBREAK;
              F12_MRET:   code_next = IC_MRET;
              F12_WFI:    code_next = IC_WFI;
              default:    code_next = IC_UNKNOWN;
            endcase
          end
          [3'd1:3'd3]: begin
            fmt_next = FMT_I;
            wr_next  = 1'b1;
            pat_next = PAT_RD_CSR_RS1;
            unique case (f3)
              3'd1:    code_next = IC_CSRRW;
              3'd2:    code_next = IC_CSRRS;
              default: code_next = IC_CSRRC;
            endcase
          end
          [3'd5:3'd7]: begin
            fmt_next = FMT_I;
            wr_next  = 1'b1;
            pat_next = PAT_RD_CSR_ZIMM;
            unique case (f3)
              3'd5:    code_next = IC_CSRRWI;
              3'd6:    code_next = IC_CSRRSI;
              default: code_next = IC_CSRRCI;
            endcase
          end
          default: begin
            code_next = IC_UNKNOWN;
          end
        endcase
      end
      default: begin
        code_next = IC_UNKNOWN;
      end
    endcase
  end

  // Sign-extended immediate for the selected format.
  always_comb begin
    unique case (fmt_next)
      FMT_I:   imm_next = {{20{sign}}, in_word[31:20]};
      FMT_S:   imm_next = {{20{sign}}, in_word[31:25], in_word[11:7]};
      FMT_B:   imm_next = {{20{sign}}, in_word[7], in_word[30:25], in_word[11:8], 1'b0};
      FMT_U:   imm_next = {in_word[31:12], 12'h000};
      FMT_J:   imm_next = {{12{sign}}, in_word[19:12], in_word[20], in_word[30:21], 1'b0};
      default: imm_next = 32'h0000_0000;
    endcase
  end

  // Branch or jump target wraps modulo 2^32.
  assign target_next = in_pc + imm_next;

  // Result register; a compressed-size word gives all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (full_size) begin
        instr_code      <= code_next;
        imm_format      <= fmt_next;
        immediate       <= imm_next;
        src1_reg        <= in_word[19:15];
        src2_reg        <= in_word[24:20];
        dest_reg        <= in_word[11:7];
        csr_index       <= f12;
        fence_order     <= in_word[27:20];
        target          <= target_next;
        writes_dest     <= wr_next;
        mem_op          <= mem_next;
        operand_pattern <= pat_next;
      end else begin
        instr_code      <= IC_UNKNOWN;
        imm_format      <= FMT_NONE;
        immediate       <= '0;
        src1_reg        <= '0;
        src2_reg        <= '0;
        dest_reg        <= '0;
        csr_index       <= '0;
        fence_order     <= '0;
        target          <= '0;
        writes_dest     <= 1'b0;
        mem_op          <= MEM_NONE;
        operand_pattern <= PAT_NONE;
      end
    end
  end

  // Every accepted item produces a result marked by done.
  assert property (@(posedge clk) disable iff (rst) start |-> ##2 done)
    else $error("accepted item produced no result");

  // A result with no immediate format carries a zero immediate.
  assert property (@(posedge clk) disable iff (rst)
    (done && (imm_format == FMT_NONE)) |-> (immediate == 32'sd0))
    else $error("immediate set without a format");

  // Memory accesses only come with an offset addressing pattern.
  assert property (@(posedge clk) disable iff (rst)
    (done && (mem_op != MEM_NONE)) |->
      ((operand_pattern == PAT_RD_OFF_RS1) || (operand_pattern == PAT_RS2_OFF_RS1)))
    else $error("memory access with a non-memory operand pattern");

  // Every class that writes a register has an operand pattern.
  assert property (@(posedge clk) disable iff (rst)
    (done && writes_dest) |-> (operand_pattern != PAT_NONE))
    else $error("register write without an operand pattern");

endmodule
